### rtl/core/xrg_pkg.sv
// shared types and constants for the xoroshiro128+ range generator
// used by xrg_ctrl, xrg_dpath and the top level
`timescale 1ns / 1ps

package xrg_pkg;

   localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_MUL_B    = 64'h94D049BB133111EB;
   localparam int unsigned ROT_A   = 55;
   localparam int unsigned SHIFT_B = 14;
   localparam int unsigned ROT_C   = 36;
   localparam int unsigned DIV_STEPS = 64;

   localparam logic [1:0] FUNC_SEED   = 2'd0;
   localparam logic [1:0] FUNC_RAW    = 2'd1;
   localparam logic [1:0] FUNC_RANGE  = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_SEED_ADD,
      OP_MUL0,
      OP_MUL1,
      OP_MUL2,
      OP_MIX27,
      OP_FIN,
      OP_DRAW,
      OP_DIV_INIT_M,
      OP_DIV_INIT_ROLL,
      OP_DIV_STEP,
      OP_SAVE_LIMIT,
      OP_RES_ZERO,
      OP_RES_RAW,
      OP_RES_LOW,
      OP_RES_FULL,
      OP_RES_MOD
   } op_type;

   typedef struct packed {
      op_type op;
      logic   kb;     // 0: first mix constant, 1: second
      logic   wsel;   // state word written at the end of a mix
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       bad;
      logic       equal;
      logic       full;
      logic       reject;
   } stat_type;

endpackage

### rtl/core/xrg_dpath.sv
// datapath: state words, shared 32x32 multiplier, bit-serial remainder unit
// depends on xrg_pkg; driven by commands from xrg_ctrl
`timescale 1ns / 1ps

module xrg_dpath import xrg_pkg::*; (
   input  logic        clock,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_seed_value,
   input  logic [31:0] req_bound_low,
   input  logic [31:0] req_bound_high,
   input  cmd_type     cmd,
   output stat_type    stat,
   output logic [63:0] rsp_value,
   output logic        rsp_bad_bounds,
   input  logic        reset
);

   logic [1:0]  func_ff;
   logic [31:0] lo_ff, hi_ff, range_ff, rem_ff, lim_ff;
   logic [63:0] acc_ff, z_ff, prod_ff, w0_ff, w1_ff, roll_ff, dvd_ff, val_ff;
   logic        bad_ff;

   logic [63:0] k, acc_sum, draw_x, mp, fin_mix;
   logic [31:0] ma, mb;
   logic [32:0] shifted;

   assign k = cmd.kb ? MIX_MUL_B : MIX_MUL_A;
   assign acc_sum = acc_ff + GOLDEN_GAMMA;
   assign draw_x = w1_ff ^ w0_ff;
   assign fin_mix = prod_ff ^ (prod_ff >> 31);
   assign shifted = {rem_ff, dvd_ff[63]};

   always_comb begin
      case (cmd.op)
         OP_MUL1: begin
            ma = z_ff[63:32];
            mb = k[31:0];
         end
         OP_MUL2: begin
            ma = z_ff[31:0];
            mb = k[63:32];
         end
         default: begin
            ma = z_ff[31:0];
            mb = k[31:0];
         end
      endcase
   end

   assign mp = {32'b0, ma} * {32'b0, mb};

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            func_ff  <= req_func;
            lo_ff    <= req_bound_low;
            hi_ff    <= req_bound_high;
            range_ff <= req_bound_high - req_bound_low + 32'd1;
            acc_ff   <= {32'b0, req_seed_value};
         end
         OP_SEED_ADD: begin
            acc_ff <= acc_sum;
            z_ff   <= acc_sum ^ (acc_sum >> 30);
         end
         OP_MUL0: prod_ff <= mp;
         OP_MUL1, OP_MUL2: prod_ff <= prod_ff + {mp[31:0], 32'b0};
         OP_MIX27: z_ff <= prod_ff ^ (prod_ff >> 27);
         OP_FIN: begin
            if (cmd.wsel) begin
               w1_ff <= fin_mix;
            end else begin
               w0_ff <= fin_mix;
            end
         end
         OP_DRAW: begin
            roll_ff <= w0_ff + w1_ff;
            w0_ff   <= {w0_ff[63-ROT_A:0], w0_ff[63:64-ROT_A]} ^ draw_x
                       ^ (draw_x << SHIFT_B);
            w1_ff   <= {draw_x[63-ROT_C:0], draw_x[63:64-ROT_C]};
         end
         OP_DIV_INIT_M: begin
            dvd_ff <= '1;
            rem_ff <= '0;
         end
         OP_DIV_INIT_ROLL: begin
            dvd_ff <= roll_ff;
            rem_ff <= '0;
         end
         OP_DIV_STEP: begin
            dvd_ff <= {dvd_ff[62:0], 1'b0};
            if (shifted >= {1'b0, range_ff}) begin
               rem_ff <= 32'(shifted - {1'b0, range_ff});
            end else begin
               rem_ff <= shifted[31:0];
            end
         end
         // limit is all ones minus the remainder of all ones by the range
         OP_SAVE_LIMIT: lim_ff <= ~rem_ff;
         OP_RES_ZERO: begin
            val_ff <= '0;
            bad_ff <= 1'b0;
         end
         OP_RES_RAW: begin
            val_ff <= roll_ff;
            bad_ff <= 1'b0;
         end
         OP_RES_LOW: begin
            val_ff <= {32'b0, lo_ff};
            bad_ff <= (lo_ff > hi_ff);
         end
         OP_RES_FULL: begin
            val_ff <= {32'b0, lo_ff + roll_ff[31:0]};
            bad_ff <= 1'b0;
         end
         OP_RES_MOD: begin
            val_ff <= {32'b0, lo_ff + rem_ff};
            bad_ff <= 1'b0;
         end
         default: ;
      endcase
      if (reset) begin
         w0_ff <= '0;
         w1_ff <= '0;
      end
   end

   assign stat.func   = func_ff;
   assign stat.bad    = lo_ff > hi_ff;
   assign stat.equal  = lo_ff == hi_ff;
   assign stat.full   = (lo_ff == 32'd0) && (hi_ff == 32'hFFFFFFFF);
   assign stat.reject = roll_ff > {32'hFFFFFFFF, lim_ff};

   assign rsp_value      = val_ff;
   assign rsp_bad_bounds = bad_ff;

endmodule

### rtl/core/xrg_ctrl.sv
// controller: sequences reseed mixing, draws, rejection and remainder passes
// depends on xrg_pkg; commands xrg_dpath
`timescale 1ns / 1ps

module xrg_ctrl import xrg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_SEED_ADD, S_MUL0, S_MUL1, S_MUL2, S_MIX27, S_FIN,
      S_DRAW_RAW, S_DRAW_FULL, S_DIV_INIT_M, S_DIV_STEP, S_SAVE_LIMIT,
      S_DRAW, S_CHECK, S_FINISH
   } state_type;

   state_type   state_ff, state_in;
   logic        kb_ff, kb_in, wsel_ff, wsel_in, phase_ff, phase_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  cnt_ff, cnt_in;
   op_type      res_ff, res_in;
   op_type      op;
   logic        out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      kb_in        = kb_ff;
      wsel_in      = wsel_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      op           = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.func)
               FUNC_SEED: begin
                  wsel_in  = 1'b0;
                  state_in = S_SEED_ADD;
               end
               FUNC_RAW: state_in = S_DRAW_RAW;
               FUNC_RANGE: begin
                  if (stat.bad || stat.equal) begin
                     res_in   = OP_RES_LOW;
                     state_in = S_FINISH;
                  end else if (stat.full) begin
                     state_in = S_DRAW_FULL;
                  end else begin
                     state_in = S_DIV_INIT_M;
                  end
               end
               default: begin
                  res_in   = OP_RES_ZERO;
                  state_in = S_FINISH;
               end
            endcase
         end
         S_SEED_ADD: begin
            op       = OP_SEED_ADD;
            kb_in    = 1'b0;
            state_in = S_MUL0;
         end
         S_MUL0: begin
            op       = OP_MUL0;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            op       = OP_MUL1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            op       = OP_MUL2;
            state_in = kb_ff ? S_FIN : S_MIX27;
         end
         S_MIX27: begin
            op       = OP_MIX27;
            kb_in    = 1'b1;
            state_in = S_MUL0;
         end
         S_FIN: begin
            op = OP_FIN;
            if (wsel_ff) begin
               res_in   = OP_RES_ZERO;
               state_in = S_FINISH;
            end else begin
               wsel_in  = 1'b1;
               state_in = S_SEED_ADD;
            end
         end
         S_DRAW_RAW: begin
            op       = OP_DRAW;
            res_in   = OP_RES_RAW;
            state_in = S_FINISH;
         end
         S_DRAW_FULL: begin
            op       = OP_DRAW;
            res_in   = OP_RES_FULL;
            state_in = S_FINISH;
         end
         S_DIV_INIT_M: begin
            op       = OP_DIV_INIT_M;
            phase_in = 1'b0;
            cnt_in   = '0;
            state_in = S_DIV_STEP;
         end
         S_DIV_STEP: begin
            op     = OP_DIV_STEP;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               if (phase_ff) begin
                  res_in   = OP_RES_MOD;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_SAVE_LIMIT;
               end
            end
         end
         S_SAVE_LIMIT: begin
            op       = OP_SAVE_LIMIT;
            state_in = S_DRAW;
         end
         S_DRAW: begin
            op       = OP_DRAW;
            state_in = S_CHECK;
         end
         // roll above the limit is thrown away and another is drawn
         S_CHECK: begin
            if (stat.reject) begin
               state_in = S_DRAW;
            end else begin
               op       = OP_DIV_INIT_ROLL;
               phase_in = 1'b1;
               cnt_in   = '0;
               state_in = S_DIV_STEP;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               op           = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kb_ff        <= 1'b0;
         wsel_ff      <= 1'b0;
         phase_ff     <= 1'b0;
         cnt_ff       <= '0;
         res_ff       <= OP_RES_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kb_ff        <= kb_in;
         wsel_ff      <= wsel_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         res_ff       <= res_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign cmd.op    = op;
   assign cmd.kb    = kb_ff;
   assign cmd.wsel  = wsel_ff;

   // a pending result must not be overwritten
   a_hold_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_FINISH))
      else $error("result issued over a pending transfer");

   // remainder counter only runs inside the division loop
   a_cnt_div: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 6'd0 && state_ff != S_DIV_STEP) |-> (state_ff == S_FINISH
         || state_ff == S_IDLE || state_ff == S_DECODE || state_ff == S_SAVE_LIMIT
         || state_ff == S_DRAW || state_ff == S_CHECK || state_ff == S_DIV_INIT_M))
      else $error("division counter active outside division");

   // each accepted item goes to decode, on its way to exactly one result
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("accepted item not decoded");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH))
      else $error("result raised outside finish");

endmodule

### rtl/core/xoroshiro128_plus_range_generator.sv
// top level of the xoroshiro128+ range generator
// depends on xrg_pkg, xrg_ctrl and xrg_dpath
`timescale 1ns / 1ps
//
// usage: one request transfer (req_func, req_seed_value, req_bound_low,
// req_bound_high) gives exactly one response transfer (rsp_value,
// rsp_bad_bounds), in order. func 0 reseeds through two splitmix64 outputs,
// func 1 returns the 64-bit sum of the state words and advances, func 2
// returns a value in [bound_low, bound_high]: equal bounds give bound_low,
// a full 32-bit span adds a raw draw, other spans use rejection sampling;
// reversed bounds give bound_low with rsp_bad_bounds set; func 3 gives zero.
// a bounded draw runs the one-bit-per-cycle remainder unit once for the
// rejection limit and once for the accepted roll. the block takes
// one item at a time; req_ready is high only while idle.
// the result sits in an output register; the next request is taken while
// it waits, and a finished item holds until rsp_ready frees the register.
// reset clears both state words, so raw draws return zero until a reseed.
//
module xoroshiro128_plus_range_generator import xrg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_seed_value,
   input  logic [31:0] req_bound_low,
   input  logic [31:0] req_bound_high,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_value,
   output logic        rsp_bad_bounds
);

   cmd_type  cmd;
   stat_type stat;

   xrg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   xrg_dpath u_dpath (
      .clock          (clock),
      .req_func       (req_func),
      .req_seed_value (req_seed_value),
      .req_bound_low  (req_bound_low),
      .req_bound_high (req_bound_high),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_value      (rsp_value),
      .rsp_bad_bounds (rsp_bad_bounds),
      .reset          (reset)
   );

endmodule

### tb/xrg_checker.sv
// watches the request and response channels of the range generator,
// predicts each response from its own copy of the generator state
// depends on xrg_pkg for the operation codes
`timescale 1ns / 1ps

module xrg_checker import xrg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_seed_value,
   input  logic [31:0] req_bound_low,
   input  logic [31:0] req_bound_high,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [63:0] rsp_value,
   input  logic        rsp_bad_bounds,
   output int          fail_count,
   output int          pending,
   output int          rsp_seen
);

   typedef struct {
      logic [63:0] value;
      logic        bad;
   } answer_type;

   logic [63:0] word0, word1;
   answer_type  answers_due[$];

   function automatic logic [63:0] rotl(logic [63:0] x, int unsigned k);
      return (x << k) | (x >> (64 - k));
   endfunction

   // one xoroshiro128+ step: returns the sum, advances the model words
   function automatic logic [63:0] next_roll();
      logic [63:0] a, b, s;
      a = word0;
      b = word1;
      s = a + b;
      b = b ^ a;
      word0 = rotl(a, ROT_A) ^ b ^ (b << SHIFT_B);
      word1 = rotl(b, ROT_C);
      return s;
   endfunction

   function automatic logic [63:0] splitmix(inout logic [63:0] acc);
      logic [63:0] z;
      acc = acc + GOLDEN_GAMMA;
      z = acc;
      z = (z ^ (z >> 30)) * MIX_MUL_A;
      z = (z ^ (z >> 27)) * MIX_MUL_B;
      return z ^ (z >> 31);
   endfunction

   function automatic answer_type predict_answer(logic [1:0] f, logic [31:0] sd,
                                                 logic [31:0] lo, logic [31:0] hi);
      answer_type  r;
      logic [63:0] acc, rng, lim, roll;
      logic [31:0] span;
      r.value = '0;
      r.bad   = 1'b0;
      case (f)
         FUNC_SEED: begin
            acc = {32'd0, sd};
            word0 = splitmix(acc);
            word1 = splitmix(acc);
         end
         FUNC_RAW: r.value = next_roll();
         FUNC_RANGE: begin
            if (lo > hi) begin
               r.value = {32'd0, lo};
               r.bad   = 1'b1;
            end else if (lo == hi) begin
               r.value = {32'd0, lo};
            end else begin
               span = hi - lo;
               if (span == 32'hFFFF_FFFF) begin
                  roll = next_roll();
                  r.value = {32'd0, lo + roll[31:0]};
               end else begin
                  rng = {32'd0, span} + 64'd1;
                  lim = rng * (64'hFFFF_FFFF_FFFF_FFFF / rng);
                  do roll = next_roll(); while (roll > lim);
                  r.value = {32'd0, lo + 32'(roll % rng)};
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   assign pending = answers_due.size();

   always @(posedge clock) begin
      answer_type e;
      int         errs;
      errs = 0;
      if (reset) begin
         word0 = '0;
         word1 = '0;
         fail_count <= 0;
         rsp_seen <= 0;
         answers_due.delete();
      end else begin
         if (req_valid && req_ready)
            answers_due.push_back(predict_answer(req_func, req_seed_value,
                                                 req_bound_low, req_bound_high));
         if (rsp_valid && rsp_ready) begin
            rsp_seen <= rsp_seen + 1;
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected response value=%h bad=%b", $time,
                        rsp_value, rsp_bad_bounds);
               errs = errs + 1;
            end else begin
               e = answers_due.pop_front();
               if (rsp_value !== e.value) begin
                  $display("%0t: value expected %h actual %h", $time, e.value, rsp_value);
                  errs = errs + 1;
               end
               if (rsp_bad_bounds !== e.bad) begin
                  $display("%0t: bad_bounds expected %b actual %b", $time, e.bad,
                           rsp_bad_bounds);
                  errs = errs + 1;
               end
            end
         end
         if (errs != 0)
            fail_count <= fail_count + errs;
      end
   end

endmodule

### tb/xoroshiro128_plus_range_generator_tb.sv
// stimulus and verdict for the xoroshiro128+ range generator
// depends on xrg_pkg, the block and xrg_checker
`timescale 1ns / 1ps

module xoroshiro128_plus_range_generator_tb;
   import xrg_pkg::*;

   localparam int CYCLE_LIMIT = 1_500_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = FUNC_SEED;
   logic [31:0] req_seed_value = '0;
   logic [31:0] req_bound_low = '0;
   logic [31:0] req_bound_high = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_value;
   logic        rsp_bad_bounds;
   int          fail_count, pending, rsp_seen;
   int          cycles = 0;
   bit          calm = 1'b0;
   int          sent_count = 0;

   always #10 clock = ~clock;

   xoroshiro128_plus_range_generator u_dut (.*);

   xrg_checker u_chk (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("xoroshiro128_plus_range_generator_tb: done, errors");
         $finish;
      end
   end

   // receiver: random stall bursts until the calm tail
   initial begin
      int n;
      @(negedge clock);
      forever begin
         rsp_ready <= 1'b1;
         n = $urandom_range(0, 12);
         repeat (n) @(negedge clock);
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end
      end
   end

   task automatic send(logic [1:0] f, logic [31:0] sd, logic [31:0] lo, logic [31:0] hi);
      req_valid      <= 1'b1;
      req_func       <= f;
      req_seed_value <= sd;
      req_bound_low  <= lo;
      req_bound_high <= hi;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent_count++;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
   endtask

   task automatic send_random();
      logic [31:0] lo, hi, w;
      int          pick;
      pick = $urandom_range(0, 19);
      lo = $urandom;
      case ($urandom_range(0, 4))
         0: w = $urandom_range(0, 3);
         1: w = $urandom_range(0, 1000);
         2: w = $urandom >> $urandom_range(0, 31);
         3: w = $urandom;
         default: w = 32'hFFFF_FFFF - $urandom_range(0, 3);
      endcase
      if ($urandom_range(0, 1)) lo = lo >> $urandom_range(0, 31);
      hi = lo + w;
      if (pick == 0) send(FUNC_SEED, $urandom, $urandom, $urandom);
      else if (pick == 1) send(FUNC_UNUSED, $urandom, $urandom, $urandom);
      else if (pick < 7) send(FUNC_RAW, $urandom, $urandom, $urandom);
      else if (pick == 7) send(FUNC_RANGE, $urandom, $urandom, $urandom);
      else send(FUNC_RANGE, $urandom, lo, hi);
   endtask

   initial begin
      int waited;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero state draws, seeds at the extremes, every bound case
      send(FUNC_RAW, '0, '0, '0);
      send(FUNC_RANGE, '0, 32'd5, 32'd100);
      send(FUNC_SEED, 32'h0, '0, '0);
      send(FUNC_RAW, '0, '0, '0);
      send(FUNC_SEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(FUNC_RAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(FUNC_RANGE, '0, 32'd7, 32'd7);
      send(FUNC_RANGE, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(FUNC_RANGE, '0, 32'd9, 32'd8);
      send(FUNC_RANGE, '0, 32'hFFFF_FFFF, 32'h0);
      send(FUNC_RANGE, '0, 32'h0, 32'hFFFF_FFFF);
      send(FUNC_RANGE, '0, 32'h0, 32'hFFFF_FFFE);
      send(FUNC_RANGE, '0, 32'h1, 32'hFFFF_FFFF);
      send(FUNC_RANGE, '0, 32'h0, 32'h1);
      send(FUNC_RANGE, '0, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send(FUNC_RANGE, '0, 32'h0, 32'h8000_0000);
      send(FUNC_RANGE, '0, 32'h5555_5555, 32'hAAAA_AAAA);
      send(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(FUNC_RAW, '0, '0, '0);
      send(FUNC_SEED, 32'h1234_5678, '0, '0);

      repeat (430) send_random();

      // hold off until the block has drained
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);

      repeat (350) send_random();
      calm = 1'b1;
      repeat (120) send_random();
      req_valid <= 1'b0;

      waited = 0;
      while (pending != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (200) @(negedge clock);
      $display("sent %0d requests (reseed, raw, bounded and unused codes), %0d responses",
               sent_count, rsp_seen);
      if (fail_count == 0 && pending == 0)
         $display("xoroshiro128_plus_range_generator_tb: done, clean");
      else
         $display("xoroshiro128_plus_range_generator_tb: done, errors");
      $finish;
   end

endmodule
